// ----- hdl/shab_pkg.sv -----
// Shared types, constants and SHA-256 helper functions for the block hash engine.
// No dependencies; used by shab_round and sha256_block_hash.
`default_nettype none

package shab_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUNDS  = 64;
    localparam int BLK_WORDS = 16;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0][WORD_W-1:0] work_t;   // [0] = a ... [7] = h

    localparam work_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t big_sig0(input word_t v);
        big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_sig1(input word_t v);
        big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t small_sig0(input word_t v);
        small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t v);
        small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/shab_round.sv -----
// One SHA-256 compression round over the eight working words.
// Depends on shab_pkg for types and sigma functions.
`default_nettype none

module shab_round (
    input  var shab_pkg::work_t cur,
    input  var shab_pkg::word_t sched_word,
    input  var shab_pkg::word_t round_const,
    output var shab_pkg::work_t nxt
);

    shab_pkg::word_t t1;
    shab_pkg::word_t t2;
    shab_pkg::word_t ch;
    shab_pkg::word_t maj;

    always_comb begin
        ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
        maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
        t1  = cur[7] + shab_pkg::big_sig1(cur[4]) + ch + round_const + sched_word;
        t2  = shab_pkg::big_sig0(cur[0]) + maj;
        nxt[7] = cur[6];
        nxt[6] = cur[5];
        nxt[5] = cur[4];
        nxt[4] = cur[3] + t1;
        nxt[3] = cur[2];
        nxt[2] = cur[1];
        nxt[1] = cur[0];
        nxt[0] = t1 + t2;
    end

endmodule

`default_nettype wire

// ----- hdl/sha256_block_hash.sv -----
// SHA-256 block hash engine: 16-word block store in a two-read-port memory, schedule
// expanded in place, four schedule reads per round. With the end flag the first
// digest beat is valid in the same cycle as the updated chain value, eight beats
// total. No input is taken while rounds run; digest beats overlap collection of the
// next block's first 15 words. Reset clears control and loads the initial hash.
`default_nettype none

module sha256_block_hash (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] message_word
    input  wire         s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] digest_index
    output logic        m_tlast    // digest_last
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_ROUND   = 2'd1;
    localparam logic [1:0] ST_FINAL   = 2'd2;
    localparam logic [1:0] ST_OUT     = 2'd3;

    localparam logic [5:0] LAST_ROUND = 6'(shab_pkg::ROUNDS - 1);
    localparam logic [3:0] LAST_POS   = 4'(shab_pkg::BLK_WORDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'd7;

    logic [1:0] state_reg, state_next;
    logic [3:0] pos_reg, pos_next;
    logic [5:0] rd_t_reg, rd_t_next;
    logic [5:0] calc_t_reg, calc_t_next;
    logic [5:0] rnd_t_reg, rnd_t_next;
    logic       phase_reg, phase_next;
    logic       calc_vld_reg, calc_vld_next;
    logic       rnd_vld_reg, rnd_vld_next;
    logic       fin_reg, fin_next;
    logic [2:0] out_idx_reg, out_idx_next;

    shab_pkg::work_t chain_reg, chain_next;
    shab_pkg::work_t work_reg, work_next;
    shab_pkg::work_t round_out;
    shab_pkg::word_t w_reg, w_next;
    shab_pkg::word_t h0_reg, h1_reg;
    shab_pkg::word_t q0_reg, q1_reg;
    shab_pkg::word_t w_calc;

    // block store / schedule window
    shab_pkg::word_t sched_mem [shab_pkg::BLK_WORDS];
    logic            mem_we;
    logic [3:0]      mem_wa;
    shab_pkg::word_t mem_wd;
    logic [3:0]      ra0, ra1;

    logic s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    assign s_tready = (state_reg == ST_COLLECT) || (state_reg == ST_OUT && pos_reg != LAST_POS);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LAST_IDX);

    shab_round u_round (
        .cur         (work_reg),
        .sched_word  (w_reg),
        .round_const (shab_pkg::ROUND_K[rnd_t_reg]),
        .nxt         (round_out)
    );

    // read addresses: phase 0 -> w[t-15], w[t-16] (w[t] while t < 16); phase 1 -> w[t-2], w[t-7]
    always_comb begin
        if (!phase_reg) begin
            ra0 = rd_t_reg[3:0] + 4'd1;
            ra1 = rd_t_reg[3:0];
        end else begin
            ra0 = rd_t_reg[3:0] - 4'd2;
            ra1 = rd_t_reg[3:0] - 4'd7;
        end
    end

    always_comb begin
        if (calc_t_reg < 6'(shab_pkg::BLK_WORDS)) begin
            w_calc = h1_reg;
        end else begin
            w_calc = shab_pkg::small_sig1(q0_reg) + q1_reg
                   + shab_pkg::small_sig0(h0_reg) + h1_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rd_t_next     = rd_t_reg;
        calc_t_next   = calc_t_reg;
        rnd_t_next    = rnd_t_reg;
        phase_next    = phase_reg;
        calc_vld_next = calc_vld_reg;
        rnd_vld_next  = rnd_vld_reg;
        fin_next      = fin_reg;
        out_idx_next  = out_idx_reg;
        chain_next    = chain_reg;
        work_next     = work_reg;
        w_next        = w_reg;
        mem_we        = 1'b0;
        mem_wa        = pos_reg;
        mem_wd        = s_tdata;

        if (s_fire) begin
            mem_we   = 1'b1;
            pos_next = pos_reg + 4'd1;
        end

        case (state_reg)
            ST_COLLECT: begin
                if (s_fire && pos_reg == LAST_POS) begin
                    state_next    = ST_ROUND;
                    fin_next      = s_tlast;
                    work_next     = chain_reg;
                    rd_t_next     = '0;
                    phase_next    = 1'b0;
                    calc_vld_next = 1'b0;
                    rnd_vld_next  = 1'b0;
                end
            end
            ST_ROUND: begin
                if (!phase_reg) begin
                    if (calc_vld_reg) begin
                        w_next        = w_calc;
                        rnd_t_next    = calc_t_reg;
                        rnd_vld_next  = 1'b1;
                        calc_vld_next = 1'b0;
                        if (calc_t_reg >= 6'(shab_pkg::BLK_WORDS)) begin
                            mem_we = 1'b1;
                            mem_wa = calc_t_reg[3:0];
                            mem_wd = w_calc;
                        end
                    end
                    phase_next = 1'b1;
                end else begin
                    if (rnd_vld_reg) begin
                        work_next    = round_out;
                        rnd_vld_next = 1'b0;
                        if (rnd_t_reg == LAST_ROUND) begin
                            state_next = ST_FINAL;
                        end
                    end
                    calc_t_next   = rd_t_reg;
                    rd_t_next     = rd_t_reg + 6'd1;
                    calc_vld_next = 1'b1;
                    phase_next    = 1'b0;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                out_idx_next = '0;
                state_next   = fin_reg ? ST_OUT : ST_COLLECT;
            end
            ST_OUT: begin
                if (m_fire) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_IDX) begin
                        chain_next = shab_pkg::INIT_HASH;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sched_mem[mem_wa] <= mem_wd;
        end
        q0_reg <= sched_mem[ra0];
        q1_reg <= sched_mem[ra1];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROUND && phase_reg) begin
            h0_reg <= q0_reg;
            h1_reg <= q1_reg;
        end
        work_reg   <= work_next;
        w_reg      <= w_next;
        calc_t_reg <= calc_t_next;
        rnd_t_reg  <= rnd_t_next;
        rd_t_reg   <= rd_t_next;
        fin_reg    <= fin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            pos_reg      <= '0;
            phase_reg    <= 1'b0;
            calc_vld_reg <= 1'b0;
            rnd_vld_reg  <= 1'b0;
            out_idx_reg  <= '0;
            chain_reg    <= shab_pkg::INIT_HASH;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            calc_vld_reg <= calc_vld_next;
            rnd_vld_reg  <= rnd_vld_next;
            out_idx_reg  <= out_idx_next;
            chain_reg    <= chain_next;
        end
    end

    a_no_block_end_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && m_tvalid) |-> (pos_reg != LAST_POS))
        else $error("block end accepted while digest pending");

    a_final_after_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |-> ($past(state_reg) == ST_ROUND && $past(rnd_t_reg) == LAST_ROUND))
        else $error("finalize entered before last round");

    a_block_starts_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && pos_reg == LAST_POS) |=> (state_reg == ST_ROUND && rd_t_reg == 6'd0))
        else $error("full block did not start compression");

    a_chain_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> (state_reg == ST_COLLECT && chain_reg == shab_pkg::INIT_HASH))
        else $error("chain not reinitialized after digest");

endmodule

`default_nettype wire

// ----- tb/sha256_block_hash_test.sv -----
`timescale 1ns / 100ps
// Testbench for sha256_block_hash: padded message words in, digest words out.
// A scoreboard class predicts each digest; a task drives the input stream and an initial block the result side.
// Depends on the RTL top level only.

module sha256_block_hash_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_PRINTS = 40;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    class digest_board;
        logic [31:0]  chain [8];
        logic [31:0]  blk [16];
        int unsigned  pos;
        digest_beat_t digest_q [$];
        int           errors;
        int           predicted;

        function new();
            int i;
            for (i = 0; i < 8; i++) chain[i] = SHA_H0[i];
            pos = 0;
            errors = 0;
            predicted = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
        endfunction

        function logic [31:0] ror32(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function logic [31:0] ep0(logic [31:0] v);
            return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
        endfunction

        function logic [31:0] ep1(logic [31:0] v);
            return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
        endfunction

        function logic [31:0] sg0(logic [31:0] v);
            return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
        endfunction

        function logic [31:0] sg1(logic [31:0] v);
            return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            int i;
            for (i = 0; i < 16; i++) w[i] = blk[i];
            for (i = 16; i < 64; i++)
                w[i] = sg1(w[i-2]) + w[i-7] + sg0(w[i-15]) + w[i-16];
            for (i = 0; i < 8; i++) v[i] = chain[i];
            for (i = 0; i < 64; i++) begin
                t1 = v[7] + ep1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
                t2 = ep0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        // accepted input beat
        function void note_word(logic [31:0] word, logic eom);
            digest_beat_t b;
            int k;
            blk[pos] = word;
            if (pos != 15) begin
                pos++;
                return;
            end
            pos = 0;
            compress();
            if (!eom) return;
            for (k = 0; k < 8; k++) begin
                b.word = chain[k];
                b.index = k[2:0];
                b.last = (k == 7);
                digest_q.push_back(b);
                predicted++;
            end
            for (k = 0; k < 8; k++) chain[k] = SHA_H0[k];
        endfunction

        // accepted output beat
        function void check_digest(logic [31:0] word, logic [2:0] index, logic last);
            digest_beat_t exp_b;
            if (digest_q.size() == 0) begin
                report($sformatf("unexpected beat data=%h index=%0d last=%b",
                                 word, index, last));
                return;
            end
            exp_b = digest_q.pop_front();
            if (word !== exp_b.word)
                report($sformatf("digest word %0d: got %h exp %h", exp_b.index, word, exp_b.word));
            if (index !== exp_b.index)
                report($sformatf("digest index: got %0d exp %0d", index, exp_b.index));
            if (last !== exp_b.last)
                report($sformatf("digest %0d last: got %b exp %b", exp_b.index, last, exp_b.last));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    digest_board board = new();
    int          cycles;
    int          words_sent;
    bit          no_gap_in;
    bit          no_gap_out;

    sha256_block_hash u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] word, input logic eom);
        int gap;
        gap = no_gap_in ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= eom;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        board.note_word(word, eom);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // one padded message of 1..3 blocks; stray end flags inside are noise
    task automatic send_message();
        int nblk;
        int i;
        logic eom;
        nblk = $urandom_range(1, 3);
        no_gap_in = ($urandom_range(0, 3) == 0);
        for (i = 0; i < nblk * 16; i++) begin
            if (i == nblk * 16 - 1) eom = 1'b1;
            else if ((i % 16) == 15) eom = ($urandom_range(0, 15) == 0) ? 1'b0 : 1'b0;
            else eom = ($urandom_range(0, 7) == 0);
            send_word(pick_word(), eom);
        end
    endtask

    // result side: random backpressure, check every beat
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) no_gap_out = ~no_gap_out;
            gap = no_gap_out ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            board.check_digest(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        int i;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        aresetn    = 1'b0;
        words_sent = 0;
        no_gap_in  = 1'b0;
        no_gap_out = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, end flag ignored mid-block, end flag on the final word
        for (i = 0; i < 16; i++) begin
            case (i % 4)
                0: send_word(32'h0000_0000, i == 3 || i == 15);
                1: send_word(32'hffff_ffff, 1'b0);
                2: send_word(32'h8000_0000, 1'b0);
                default: send_word(32'h0000_0001, i == 3 || i == 15);
            endcase
        end

        while (words_sent < 144 || board.predicted < 40)
            send_message();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (board.digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
